// ----- design/srsw_pkg.sv -----
// Shared types and constants for the selective-repeat sender window.
// Holds payload structs, lane and round records and register indexes.
// No dependencies.
package srsw_pkg;

   localparam int WINDOW_MAX        = 16;
   localparam int FRAME_NUMBER_BITS = 16;
   localparam int SLOT_BITS         = $clog2(WINDOW_MAX);
   localparam int OFS_BITS          = $clog2(WINDOW_MAX + 1);
   localparam int WL_BITS           = 5;
   localparam int FT_BITS           = 16;
   localparam int MASK_BITS         = 16;
   localparam int CNT_BITS          = 32;
   localparam int CSR_INDEX_BITS    = 4;
   localparam int CSR_DATA_BITS     = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_LENGTH = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_TOTAL   = CSR_INDEX_BITS'(1);

   localparam logic [WL_BITS-1:0] WL_RESET = WL_BITS'(4);
   localparam logic [FT_BITS-1:0] FT_RESET = FT_BITS'(10);

   typedef struct packed {
      logic [MASK_BITS-1:0] frame_loss_mask;
      logic [MASK_BITS-1:0] ack_loss_mask;
   } req_payload_type;

   typedef struct packed {
      logic [15:0]         frame_number;
      logic                lost_frame;
      logic                lost_ack;
      logic                now_acked;
      logic                last_of_round;
      logic [15:0]         window_base;
      logic                all_done;
      logic [CNT_BITS-1:0] sent_count;
      logic [CNT_BITS-1:0] frame_loss_count;
      logic [CNT_BITS-1:0] ack_loss_count;
   } rsp_payload_type;

   typedef struct packed {
      logic send;
      logic lost_frame;
      logic lost_ack;
      logic now_acked;
   } lane_out_type;

   typedef struct packed {
      logic [WINDOW_MAX-1:0]        send_mask;
      logic [WINDOW_MAX-1:0]        lf_mask;
      logic [WINDOW_MAX-1:0]        la_mask;
      logic [FRAME_NUMBER_BITS-1:0] start_before;
      logic [FRAME_NUMBER_BITS-1:0] base_after;
      logic                         done;
   } round_type;

   typedef struct packed {
      logic busy;
      logic finishing;
   } emit_status_type;

endpackage

// ----- design/selective_repeat_sender_window_top.sv -----
// Selective-repeat ARQ sender window, top level. Depends on srsw_pkg,
// srsw_lane, srsw_merge and srsw_emit.
//
// Each accepted item is one transmission round. Sixteen lanes judge every
// window offset at once in the accept cycle; the merging stage updates the
// acknowledgement ring and slides the window there, so the window state is
// final as soon as the item is taken. The emitter then gives one result per
// cycle unless rsp_stall holds the output: one per frame sent, or a single
// status result when nothing is sent. A round yields 1 to window_length
// results (window_length clamped to 1..16); the next item is taken on the
// cycle the last result enters the output register. No clearing pass is
// needed after reset. Write configuration only while no round is open.
module selective_repeat_sender_window_top
   import srsw_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_payload_type           req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_payload_type           rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   logic [WL_BITS-1:0]           wl_ff, wl_in;
   logic [FT_BITS-1:0]           ft_ff, ft_in;
   logic [WINDOW_MAX-1:0]        ring_ff, ring_in;
   logic [FRAME_NUMBER_BITS-1:0] start_ff, start_in;

   logic [WL_BITS-1:0]            wl_eff;
   logic [2*WINDOW_MAX-1:0]       rot_wide;
   logic [WINDOW_MAX-1:0]         ring_rot;
   lane_out_type [WINDOW_MAX-1:0] lanes;
   logic [WINDOW_MAX-1:0]         ring_after;
   round_type                     round;
   emit_status_type               emit_status;
   logic                          accept;

   assign csr_ready = 1'b1;
   assign req_stall = emit_status.busy && !emit_status.finishing;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      wl_in = wl_ff;
      ft_in = ft_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_WINDOW_LENGTH: wl_in = csr_data[WL_BITS-1:0];
            CSR_FRAME_TOTAL:   ft_in = csr_data[FT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (wl_ff == '0) begin
         wl_eff = WL_BITS'(1);
      end else if (wl_ff > WL_BITS'(WINDOW_MAX)) begin
         wl_eff = WL_BITS'(WINDOW_MAX);
      end else begin
         wl_eff = wl_ff;
      end
      rot_wide = {ring_ff, ring_ff} >> start_ff[SLOT_BITS-1:0];
      ring_rot = rot_wide[WINDOW_MAX-1:0];
   end

   for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_lane
      srsw_lane u_lane (
         .lane_offset (SLOT_BITS'(k)),
         .start       (start_ff),
         .frame_total (ft_ff),
         .window_len  (wl_eff),
         .acked       (ring_rot[k]),
         .frame_loss  (req_payload.frame_loss_mask[k]),
         .ack_drop    (req_payload.ack_loss_mask[k]),
         .lane_out    (lanes[k])
      );
   end

   srsw_merge u_merge (
      .lanes       (lanes),
      .ring_rot    (ring_rot),
      .start       (start_ff),
      .frame_total (ft_ff),
      .ring_after  (ring_after),
      .round       (round)
   );

   always_comb begin
      ring_in  = ring_ff;
      start_in = start_ff;
      if (accept) begin
         ring_in  = ring_after;
         start_in = round.base_after;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wl_ff    <= WL_RESET;
         ft_ff    <= FT_RESET;
         ring_ff  <= '0;
         start_ff <= '0;
      end else begin
         wl_ff    <= wl_in;
         ft_ff    <= ft_in;
         ring_ff  <= ring_in;
         start_ff <= start_in;
      end
   end

   srsw_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .load        (accept),
      .round_in    (round),
      .status      (emit_status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

`ifndef ASSERT_OFF
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.all_done) |-> rsp_payload.last_of_round)
      else $error("all_done on a result that does not close its round");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.now_acked &&
                      (rsp_payload.lost_frame || rsp_payload.lost_ack)) &&
                    !(rsp_payload.lost_frame && rsp_payload.lost_ack))
      else $error("conflicting acknowledgement flags on a result");

   a_base_slot_clear: assert property (@(posedge clock) disable iff (reset)
      accept |=> ((start_ff >= FRAME_NUMBER_BITS'(ft_ff)) ||
                  !ring_ff[start_ff[SLOT_BITS-1:0]]))
      else $error("window did not slide past an acknowledged base frame");

   a_round_opens: assert property (@(posedge clock) disable iff (reset)
      accept |=> emit_status.busy)
      else $error("accepted item did not open a round in the emitter");
`endif

endmodule

// ----- design/srsw_lane.sv -----
// One window lane: decides whether the frame at its offset is sent and
// what the round's masks make of it. Depends on srsw_pkg.
module srsw_lane
   import srsw_pkg::*;
(
   input  logic [SLOT_BITS-1:0]         lane_offset,
   input  logic [FRAME_NUMBER_BITS-1:0] start,
   input  logic [FT_BITS-1:0]           frame_total,
   input  logic [WL_BITS-1:0]           window_len,
   input  logic                         acked,
   input  logic                         frame_loss,
   input  logic                         ack_drop,
   output lane_out_type                 lane_out
);

   logic [FRAME_NUMBER_BITS:0] fnum;
   logic                       in_window;
   logic                       send;

   always_comb begin
      fnum      = {1'b0, start} + (FRAME_NUMBER_BITS + 1)'(lane_offset);
      in_window = WL_BITS'(lane_offset) < window_len;
      send      = in_window && (fnum < (FRAME_NUMBER_BITS + 1)'(frame_total)) && !acked;
      lane_out.send       = send;
      lane_out.lost_frame = send && frame_loss;
      lane_out.lost_ack   = send && !frame_loss && ack_drop;
      lane_out.now_acked  = send && !frame_loss && !ack_drop;
   end

endmodule

// ----- design/srsw_merge.sv -----
// Merging stage: folds lane results into the ring, slides the window
// past acknowledged frames and builds the round record. Depends on srsw_pkg.
module srsw_merge
   import srsw_pkg::*;
(
   input  lane_out_type [WINDOW_MAX-1:0] lanes,
   input  logic [WINDOW_MAX-1:0]         ring_rot,
   input  logic [FRAME_NUMBER_BITS-1:0]  start,
   input  logic [FT_BITS-1:0]            frame_total,
   output logic [WINDOW_MAX-1:0]         ring_after,
   output round_type                     round
);

   logic [WINDOW_MAX-1:0]        na_mask;
   logic [WINDOW_MAX-1:0]        bound;
   logic [WINDOW_MAX-1:0]        r1;
   logic [WINDOW_MAX-1:0]        r2;
   logic [WINDOW_MAX:0]          q;
   logic [WINDOW_MAX:0]          first_zero;
   logic [WINDOW_MAX:0]          ones;
   logic [OFS_BITS-1:0]          slide;
   logic [FRAME_NUMBER_BITS-1:0] new_start;
   logic [2*WINDOW_MAX-1:0]      derot;
   logic [SLOT_BITS-1:0]         start_slot;

   always_comb begin
      start_slot = start[SLOT_BITS-1:0];
      for (int i = 0; i < WINDOW_MAX; i++) begin
         round.send_mask[i] = lanes[i].send;
         round.lf_mask[i]   = lanes[i].lost_frame;
         round.la_mask[i]   = lanes[i].lost_ack;
         na_mask[i]         = lanes[i].now_acked;
         bound[i] = ({1'b0, start} + (FRAME_NUMBER_BITS + 1)'(i))
                    < (FRAME_NUMBER_BITS + 1)'(frame_total);
      end
      r1         = ring_rot | na_mask;
      q          = {1'b0, r1 & bound};
      first_zero = ~q & (q + (WINDOW_MAX + 1)'(1));
      ones       = first_zero - (WINDOW_MAX + 1)'(1);
      slide      = '0;
      for (int i = 0; i <= WINDOW_MAX; i++) begin
         if (first_zero[i]) begin
            slide = slide | OFS_BITS'(i);
         end
      end
      r2         = r1 & ~ones[WINDOW_MAX-1:0];
      derot      = {r2, r2} << start_slot;
      ring_after = derot[2*WINDOW_MAX-1:WINDOW_MAX];
      new_start  = start + FRAME_NUMBER_BITS'(slide);
      round.start_before = start;
      round.base_after   = new_start;
      round.done         = {1'b0, new_start} >= (FRAME_NUMBER_BITS + 1)'(frame_total);
   end

endmodule

// ----- design/srsw_emit.sv -----
// Result emitter: walks the round's send mask one item per cycle unless
// stalled; keeps saturating counters and the output register. Depends on srsw_pkg.
module srsw_emit
   import srsw_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  round_type       round_in,
   output emit_status_type status,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic                  busy_ff, busy_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_payload_ff, rsp_payload_in;
   round_type             round_ff, round_in_sel;
   logic [WINDOW_MAX-1:0] pend_ff, pend_in;
   logic [CNT_BITS-1:0]   sent_ff, sent_in;
   logic [CNT_BITS-1:0]   floss_ff, floss_in;
   logic [CNT_BITS-1:0]   aloss_ff, aloss_in;

   logic                  out_free;
   logic                  fire;
   logic [WINDOW_MAX-1:0] pick;
   logic [WINDOW_MAX-1:0] remain;
   logic [SLOT_BITS-1:0]  idx;
   logic                  last;
   logic                  lf;
   logic                  la;

   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      fire     = busy_ff && out_free;
      pick     = pend_ff & (~pend_ff + WINDOW_MAX'(1));
      remain   = pend_ff & ~pick;
      last     = (remain == '0);
      idx      = '0;
      for (int k = 0; k < WINDOW_MAX; k++) begin
         if (pick[k]) begin
            idx = idx | SLOT_BITS'(k);
         end
      end
      lf = |(pick & round_ff.lf_mask);
      la = |(pick & round_ff.la_mask);

      status.busy      = busy_ff;
      status.finishing = fire && last;

      busy_in      = busy_ff;
      pend_in      = pend_ff;
      round_in_sel = round_ff;
      sent_in      = sent_ff;
      floss_in     = floss_ff;
      aloss_in     = aloss_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;

      if (fire) begin
         rsp_valid_in = 1'b1;
         busy_in      = !last;
         pend_in      = remain;
         if (pend_ff != '0) begin
            sent_in = (sent_ff == '1) ? sent_ff : sent_ff + CNT_BITS'(1);
            if (lf) begin
               floss_in = (floss_ff == '1) ? floss_ff : floss_ff + CNT_BITS'(1);
            end
            if (la) begin
               aloss_in = (aloss_ff == '1) ? aloss_ff : aloss_ff + CNT_BITS'(1);
            end
            rsp_payload_in.frame_number = 16'(round_ff.start_before + FRAME_NUMBER_BITS'(idx));
            rsp_payload_in.lost_frame   = lf;
            rsp_payload_in.lost_ack     = la;
            rsp_payload_in.now_acked    = !lf && !la;
            rsp_payload_in.last_of_round = last;
            rsp_payload_in.window_base  = last ? 16'(round_ff.base_after)
                                               : 16'(round_ff.start_before);
            rsp_payload_in.all_done     = last && round_ff.done;
         end else begin
            rsp_payload_in.frame_number  = '0;
            rsp_payload_in.lost_frame    = 1'b0;
            rsp_payload_in.lost_ack      = 1'b0;
            rsp_payload_in.now_acked     = 1'b0;
            rsp_payload_in.last_of_round = 1'b1;
            rsp_payload_in.window_base   = 16'(round_ff.base_after);
            rsp_payload_in.all_done      = round_ff.done;
         end
         rsp_payload_in.sent_count       = sent_in;
         rsp_payload_in.frame_loss_count = floss_in;
         rsp_payload_in.ack_loss_count   = aloss_in;
      end

      if (load) begin
         busy_in      = 1'b1;
         pend_in      = round_in.send_mask;
         round_in_sel = round_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sent_ff      <= '0;
         floss_ff     <= '0;
         aloss_ff     <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         sent_ff      <= sent_in;
         floss_ff     <= floss_in;
         aloss_ff     <= aloss_in;
      end
      pend_ff        <= pend_in;
      round_ff       <= round_in_sel;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
